/* sv/sorted_posting_list_table_assert.svh */
// ----------------------------------------------------------------------------
// Sorted posting list table: assertion macros
// Concurrent assertion wrappers on clk with arst_n as disable; empty for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_POSTING_LIST_TABLE_ASSERT_SVH
`define SORTED_POSTING_LIST_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SPLT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SPLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SPLT_ASSERT_IMPL(label, ante, cons, msg)
`define SPLT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* sv/splt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted posting list table: package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package splt_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DOC_ID_W     = 32;
	localparam int FREQ_W       = 16;
	localparam int DOC_COUNT_W  = 7;
	localparam int CMD_W        = 2;

	localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
	localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1);

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Command codes; code 3 is unused and answered with an empty result
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_LIST  = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_MISS,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INSERT,
		S_LIST_RD,
		S_LIST_EMIT,
		S_NULL
	} state_t;

	// One stored table entry
	typedef struct packed {
		logic [DOC_ID_W-1:0] doc_id;
		logic [FREQ_W-1:0]   freq;
	} entry_t;

	// One result transaction
	typedef struct packed {
		logic [DOC_ID_W-1:0]    entry_doc_id;
		logic [FREQ_W-1:0]      entry_frequency;
		logic [DOC_COUNT_W-1:0] doc_count;
		logic                   entry_valid;
		logic                   status;
		logic                   last;
	} result_t;

endpackage

/* sv/splt_if.sv */
// ----------------------------------------------------------------------------
// Sorted posting list table: channel interfaces
// Request channel (command and id) and result channel, valid/ready.
// ----------------------------------------------------------------------------
interface splt_req_if;
	logic                         valid;
	logic                         ready;
	logic [splt_pkg::CMD_W-1:0]    cmd;
	logic [splt_pkg::DOC_ID_W-1:0] doc_id;

	modport source (output valid, output cmd, output doc_id, input ready);
	modport sink   (input valid, input cmd, input doc_id, output ready);
endinterface

interface splt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [splt_pkg::DOC_ID_W-1:0]    entry_doc_id;
	logic [splt_pkg::FREQ_W-1:0]      entry_frequency;
	logic [splt_pkg::DOC_COUNT_W-1:0] doc_count;
	logic                            entry_valid;
	logic                            status;
	logic                            last;

	modport source (output valid, output entry_doc_id, output entry_frequency,
		output doc_count, output entry_valid, output status, output last,
		input ready);
	modport sink   (input valid, input entry_doc_id, input entry_frequency,
		input doc_count, input entry_valid, input status, input last,
		output ready);
endinterface

/* sv/splt_mem.sv */
// ----------------------------------------------------------------------------
// Sorted posting list table: entry memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module splt_mem #(
	parameter int DEPTH = splt_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  splt_pkg::entry_t wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output splt_pkg::entry_t rd_data
);
	import splt_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/sorted_posting_list_table.sv */
// ----------------------------------------------------------------------------
// Sorted posting list table
// Posting list of document ids kept in ascending order with 16-bit counts.
// ----------------------------------------------------------------------------
// Usage:
//   req carries cmd and doc_id: add an occurrence, query a count, or list the
//   table. rsp carries one result per add/query/unused command, and one per
//   stored entry for a list (a single invalid result if the table is empty);
//   last marks the final result of each request.
//   One request is worked at a time; req.ready is high only while idle. The
//   entries sit in a single-port-read memory and are walked by one compare
//   unit, which reads each entry visited and then acts on it:
//     add/query : scan the entries below the id's position, then hit or miss
//     insert    : then move the upper entries up one place, top first
//     list      : read and then emit each stored entry in order
//   Results go through an output register; the next request is accepted while
//   the last result still waits. A stalled rsp holds the sequencer at its next
//   result and the payload stays steady.
//   Reset (arst_n low) empties the table at once; the memory is not cleared
//   since entries at or above the count are never read.
// ----------------------------------------------------------------------------
`include "sorted_posting_list_table_assert.svh"

module sorted_posting_list_table #(
	parameter int CAPACITY = splt_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	splt_req_if.sink   req,
	splt_rsp_if.source rsp
);
	import splt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);

	state_t  state_q, state_d;
	cmd_t    cmd_q;
	logic [DOC_ID_W-1:0] key_q;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] sh_q, sh_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] sh_m1;
	logic [CW-1:0] count_p1;
	result_t rsp_q, res_d;
	logic    rsp_vld_q;
	logic    emit;
	logic    out_free;
	logic    accept;

	logic    wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	entry_t  wr_data, rd_data;

	logic    id_lt, id_eq;
	logic [FREQ_W-1:0] freq_inc;

	splt_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Shared compare unit and saturating increment
	assign id_lt    = rd_data.doc_id < key_q;
	assign id_eq    = rd_data.doc_id == key_q;
	assign freq_inc = (rd_data.freq == FREQ_MAX) ? FREQ_MAX : rd_data.freq + FREQ_ONE;

	assign sh_m1    = sh_q - ONE_CNT;
	assign count_p1 = count_q + ONE_CNT;
	assign out_free = !rsp_vld_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign accept   = req.valid && req.ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, memory controls and result
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		sh_d    = sh_q;
		count_d = count_q;
		emit    = 1'b0;
		res_d   = '0;
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = '0;
		res_d.doc_count = DOC_COUNT_W'(count_q);
		res_d.status    = STATUS_OK;
		res_d.last      = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					idx_d = '0;
					case (req.cmd)
						CMD_ADD, CMD_QUERY: state_d = S_SCAN_RD;
						CMD_LIST: state_d = (count_q == '0) ? S_NULL : S_LIST_RD;
						default: state_d = S_NULL;
					endcase
				end
			end
			// Fetch the next entry, or stop at the end of the table
			S_SCAN_RD: begin
				if (idx_q == count_q) begin
					state_d = S_MISS;
				end else begin
					rd_en   = 1'b1;
					state_d = S_SCAN_CMP;
				end
			end
			// Compare with the key: move on, hit, or position found
			S_SCAN_CMP: begin
				if (id_lt) begin
					idx_d   = idx_q + ONE_CNT;
					state_d = S_SCAN_RD;
				end else if (id_eq) begin
					if (out_free) begin
						emit = 1'b1;
						res_d.entry_doc_id    = key_q;
						res_d.entry_frequency = (cmd_q == CMD_ADD) ? freq_inc : rd_data.freq;
						res_d.entry_valid     = 1'b1;
						wr_en          = (cmd_q == CMD_ADD);
						wr_data.doc_id = key_q;
						wr_data.freq   = freq_inc;
						state_d        = S_IDLE;
					end
				end else begin
					state_d = S_MISS;
				end
			end
			// Id absent; idx_q is its insert position
			S_MISS: begin
				if (cmd_q == CMD_ADD && count_q != CAP_CNT) begin
					sh_d    = count_q;
					state_d = S_SHIFT_RD;
				end else if (out_free) begin
					emit = 1'b1;
					res_d.entry_doc_id = key_q;
					res_d.status = (cmd_q == CMD_ADD) ? STATUS_FULL : STATUS_OK;
					state_d = S_IDLE;
				end
			end
			// Move entries up one place, top first
			S_SHIFT_RD: begin
				if (sh_q == idx_q) begin
					state_d = S_INSERT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = sh_m1[AW-1:0];
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = sh_q[AW-1:0];
				wr_data = rd_data;
				sh_d    = sh_m1;
				state_d = S_SHIFT_RD;
			end
			S_INSERT: begin
				if (out_free) begin
					wr_en          = 1'b1;
					wr_data.doc_id = key_q;
					wr_data.freq   = FREQ_ONE;
					count_d        = count_p1;
					emit           = 1'b1;
					res_d.entry_doc_id    = key_q;
					res_d.entry_frequency = FREQ_ONE;
					res_d.doc_count       = DOC_COUNT_W'(count_p1);
					res_d.entry_valid     = 1'b1;
					state_d = S_IDLE;
				end
			end
			// Walk the table in order
			S_LIST_RD: begin
				rd_en   = 1'b1;
				state_d = S_LIST_EMIT;
			end
			S_LIST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					res_d.entry_doc_id    = rd_data.doc_id;
					res_d.entry_frequency = rd_data.freq;
					res_d.entry_valid     = 1'b1;
					res_d.last            = (idx_q == count_q - ONE_CNT);
					if (res_d.last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + ONE_CNT;
						state_d = S_LIST_RD;
					end
				end
			end
			// Empty list or unused command
			S_NULL: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (emit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// Request, walk pointers and output payload
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		sh_q  <= sh_d;
		if (accept) begin
			cmd_q <= cmd_t'(req.cmd);
			key_q <= req.doc_id;
		end
		if (emit) begin
			rsp_q <= res_d;
		end
	end

	assign rsp.valid           = rsp_vld_q;
	assign rsp.entry_doc_id    = rsp_q.entry_doc_id;
	assign rsp.entry_frequency = rsp_q.entry_frequency;
	assign rsp.doc_count       = rsp_q.doc_count;
	assign rsp.entry_valid     = rsp_q.entry_valid;
	assign rsp.status          = rsp_q.status;
	assign rsp.last            = rsp_q.last;

	// Checks
	`SPLT_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CAP_CNT, "entry count above capacity")
	`SPLT_ASSERT_NEXT(a_count_steady, !(state_q == S_INSERT && emit), $stable(count_q), "entry count changed outside insert")
	`SPLT_ASSERT_IMPL(a_emit_free, emit, !rsp_vld_q || rsp.ready, "result overwrote a pending transaction")
	`SPLT_ASSERT_IMPL(a_query_no_write, state_q != S_IDLE && cmd_q != CMD_ADD, !wr_en, "memory written outside an add")

endmodule

/* sim/sorted_posting_list_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted posting list table: testbench
// Drives add, query, list and unused requests and checks every result,
// field by field, against a behavioural copy of the table kept in here
// or, for the typed directed rows, against their given result. A short
// directed table comes first, then random traffic that fills the table,
// drops adds once it is full, and lists it while the result side is held off.
// ----------------------------------------------------------------------------
module sorted_posting_list_table_tb;
	import splt_pkg::*;

	localparam int TABLE_DEPTH   = CAPACITY_DEF;
	localparam int CLK_PERIOD    = 4;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int DIRECTED_ROWS = 18;
	localparam int RANDOM_ITEMS  = 350;
	localparam int CALM_ITEMS    = 60;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 16;

	// One row of the directed table; want is only used when typed is set
	typedef struct {
		logic [CMD_W-1:0]    cmd;
		logic [DOC_ID_W-1:0] doc_id;
		bit                  typed;
		result_t             want;
	} request_row_t;

	logic clk = 1'b0;
	logic arst_n;

	splt_req_if req_ch ();
	splt_rsp_if rsp_ch ();

	sorted_posting_list_table #(
		.CAPACITY(TABLE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the table
	logic [DOC_ID_W-1:0] model_ids [TABLE_DEPTH];
	logic [FREQ_W-1:0]   model_counts [TABLE_DEPTH];
	int                  model_fill = 0;

	result_t awaited_results [$];
	int      fail_count  = 0;
	int      stall_count = 0;
	int      rx_hold_len = 0;
	bit      tx_gaps     = 1'b1;
	bit      rx_gaps     = 1'b1;

	request_row_t directed_rows [DIRECTED_ROWS];

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic result_t mk_result(input logic [DOC_ID_W-1:0] id,
			input logic [FREQ_W-1:0] freq, input int count, input logic valid,
			input logic status, input logic last);
		result_t r;
		r.entry_doc_id    = id;
		r.entry_frequency = freq;
		r.doc_count       = DOC_COUNT_W'(count);
		r.entry_valid     = valid;
		r.status          = status;
		r.last            = last;
		return r;
	endfunction

	// Applies one request to the shadow table and returns the results it causes
	task automatic posting_table_step(input logic [CMD_W-1:0] cmd,
			input logic [DOC_ID_W-1:0] id, output result_t batch [$]);
		int  pos;
		bit  hit;
		batch = {};
		pos = 0;
		while (pos < model_fill && model_ids[pos] < id)
			pos++;
		hit = (pos < model_fill) && (model_ids[pos] == id);
		case (cmd)
			CMD_ADD: begin
				if (hit) begin
					if (model_counts[pos] != FREQ_MAX)
						model_counts[pos]++;
					batch = {batch, mk_result(id, model_counts[pos], model_fill, 1'b1,
						STATUS_OK, 1'b1)};
				end else if (model_fill >= TABLE_DEPTH) begin
					batch = {batch, mk_result(id, '0, model_fill, 1'b0, STATUS_FULL, 1'b1)};
				end else begin
					// open a slot by moving the upper entries up one place
					for (int k = model_fill; k > pos; k--) begin
						model_ids[k]    = model_ids[k-1];
						model_counts[k] = model_counts[k-1];
					end
					model_ids[pos]    = id;
					model_counts[pos] = FREQ_ONE;
					model_fill++;
					batch = {batch, mk_result(id, FREQ_ONE, model_fill, 1'b1, STATUS_OK,
						1'b1)};
				end
			end
			CMD_QUERY: begin
				if (hit)
					batch = {batch, mk_result(id, model_counts[pos], model_fill, 1'b1,
						STATUS_OK, 1'b1)};
				else
					batch = {batch, mk_result(id, '0, model_fill, 1'b0, STATUS_OK, 1'b1)};
			end
			CMD_LIST: begin
				if (model_fill == 0)
					batch = {batch, mk_result('0, '0, 0, 1'b0, STATUS_OK, 1'b1)};
				for (int k = 0; k < model_fill; k++)
					batch = {batch, mk_result(model_ids[k], model_counts[k], model_fill,
						1'b1, STATUS_OK, k == model_fill - 1)};
			end
			default: begin
				batch = {batch, mk_result('0, '0, model_fill, 1'b0, STATUS_OK, 1'b1)};
			end
		endcase
	endtask

	// Offers one request, waits for it to be taken and records its results
	task automatic send_request(input logic [CMD_W-1:0] cmd,
			input logic [DOC_ID_W-1:0] id, input bit typed, input result_t want);
		result_t batch [$];
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.cmd    <= cmd;
		req_ch.doc_id <= id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		posting_table_step(cmd, id, batch);
		if (typed)
			awaited_results = {awaited_results, want};
		else
			awaited_results = {awaited_results, batch};
	endtask

	// Withdraws the request and waits for every outstanding result
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Mostly stored ids and their neighbours, otherwise anything at all
	function automatic logic [DOC_ID_W-1:0] choose_doc_id(input int hit_pct);
		logic [DOC_ID_W-1:0] id;
		id = $urandom;
		if (model_fill > 0 && $urandom_range(0, 99) < hit_pct) begin
			id = model_ids[$urandom_range(0, model_fill - 1)];
			case ($urandom_range(0, 5))
				0: id = id + 1'b1;
				1: id = id - 1'b1;
				default: ;
			endcase
		end
		return id;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("%0t ERROR %s", $realtime, what);
	endtask

	// Result side: random back-pressure, plus the long hold on request
	initial begin
		int gap;
		forever begin
			gap = 0;
			if (rx_hold_len > 0) begin
				gap = rx_hold_len;
				rx_hold_len = 0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 11);
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result transaction, doc id %h",
					rsp_ch.entry_doc_id));
			end else begin
				want = awaited_results.pop_front();
				if (rsp_ch.entry_doc_id !== want.entry_doc_id)
					report_mismatch($sformatf("entry_doc_id %h, expected %h",
						rsp_ch.entry_doc_id, want.entry_doc_id));
				if (rsp_ch.entry_frequency !== want.entry_frequency)
					report_mismatch($sformatf("entry_frequency %0d, expected %0d (id %h)",
						rsp_ch.entry_frequency, want.entry_frequency, want.entry_doc_id));
				if (rsp_ch.doc_count !== want.doc_count)
					report_mismatch($sformatf("doc_count %0d, expected %0d",
						rsp_ch.doc_count, want.doc_count));
				if (rsp_ch.entry_valid !== want.entry_valid)
					report_mismatch($sformatf("entry_valid %b, expected %b (id %h)",
						rsp_ch.entry_valid, want.entry_valid, want.entry_doc_id));
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %b, expected %b (id %h)",
						rsp_ch.status, want.status, want.entry_doc_id));
				if (rsp_ch.last !== want.last)
					report_mismatch($sformatf("last %b, expected %b (id %h)",
						rsp_ch.last, want.last, want.entry_doc_id));
			end
		end
	end

	// Watchdog: cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int                  i;
		int                  pick;
		bit                  hold_done;
		bit                  calm;
		logic [CMD_W-1:0]    cmd;
		logic [DOC_ID_W-1:0] id;

		req_ch.valid  <= 1'b0;
		req_ch.cmd    <= CMD_ADD;
		req_ch.doc_id <= '0;
		arst_n        <= 1'b0;

		// directed table: empty table, id extremes, hits, ordered inserts
		directed_rows = '{
			'{CMD_LIST,   32'h1234_5678, 1'b1, mk_result('0, '0, 0, 1'b0, STATUS_OK, 1'b1)},
			'{CMD_QUERY,  32'hFFFF_FFFF, 1'b1,
				mk_result(32'hFFFF_FFFF, '0, 0, 1'b0, STATUS_OK, 1'b1)},
			'{CMD_UNUSED, 32'hA5A5_A5A5, 1'b1, mk_result('0, '0, 0, 1'b0, STATUS_OK, 1'b1)},
			'{CMD_ADD,    32'h0000_0000, 1'b1, mk_result('0, FREQ_ONE, 1, 1'b1, STATUS_OK, 1'b1)},
			'{CMD_ADD,    32'hFFFF_FFFF, 1'b1,
				mk_result(32'hFFFF_FFFF, FREQ_ONE, 2, 1'b1, STATUS_OK, 1'b1)},
			'{CMD_ADD,    32'h8000_0000, 1'b1,
				mk_result(32'h8000_0000, FREQ_ONE, 3, 1'b1, STATUS_OK, 1'b1)},
			'{CMD_ADD,    32'h8000_0000, 1'b1,
				mk_result(32'h8000_0000, 16'd2, 3, 1'b1, STATUS_OK, 1'b1)},
			'{CMD_ADD,    32'h7FFF_FFFF, 1'b0, '0},
			'{CMD_ADD,    32'h0000_0001, 1'b0, '0},
			'{CMD_ADD,    32'h5A5A_5A5A, 1'b0, '0},
			'{CMD_QUERY,  32'h8000_0000, 1'b0, '0},
			'{CMD_QUERY,  32'h8000_0001, 1'b0, '0},
			'{CMD_QUERY,  32'h0000_0000, 1'b0, '0},
			'{CMD_LIST,   32'hFFFF_FFFF, 1'b0, '0},
			'{CMD_UNUSED, 32'h0000_0000, 1'b0, '0},
			'{CMD_ADD,    32'hFFFF_FFFE, 1'b0, '0},
			'{CMD_QUERY,  32'hFFFF_FFFF, 1'b0, '0},
			'{CMD_LIST,   32'h0000_0000, 1'b0, '0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_request(directed_rows[k].cmd, directed_rows[k].doc_id,
				directed_rows[k].typed, directed_rows[k].want);
		wait_drained();

		// random traffic; the table fills up part way through
		i = 0;
		hold_done = 1'b0;
		while (i < RANDOM_ITEMS || !hold_done) begin
			calm    = i >= RANDOM_ITEMS - CALM_ITEMS;
			tx_gaps = !calm && (i % 50 < 35);
			rx_gaps = !calm && ((i + 20) % 50 < 35);
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			// full table listed while results are held back
			if (!hold_done && model_fill == TABLE_DEPTH) begin
				hold_done   = 1'b1;
				rx_hold_len = LONG_HOLD;
				send_request(CMD_LIST, $urandom, 1'b0, '0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				cmd = CMD_ADD;
				id  = choose_doc_id(55);
			end else if (pick < 80) begin
				cmd = CMD_QUERY;
				id  = choose_doc_id(60);
			end else if (pick < 92) begin
				cmd = CMD_LIST;
				id  = $urandom;
			end else begin
				cmd = CMD_UNUSED;
				id  = $urandom;
			end
			send_request(cmd, id, 1'b0, '0);
			i++;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
